/* design/sacache_pkg.sv */
// Shared types, defaults and helper functions for the set-associative cache tag store.
`timescale 1ns / 1ps

package sacache_pkg;

  localparam int SETS_DEF       = 64;
  localparam int WAYS_DEF       = 4;
  localparam int BLOCK_BYTES_DEF = 32;
  localparam int VC_ENTRIES_DEF = 8;
  localparam int ADDR_W         = 32;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // One queued access as it arrives from the requester.
  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
  } req_t;

  // One access outcome for the next level.
  typedef struct packed {
    logic              hit;
    logic              swap_request;
    logic              swap_hit;
    logic              writeback_valid;
    logic [ADDR_W-1:0] writeback_block;
    logic              fetch_valid;
    logic [ADDR_W-1:0] fetch_block;
  } res_t;

  // Rounds down, so sizes that are not powers of two use the lower width.
  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

/* design/sacache_fifo.sv */
// Small synchronous queue used on both sides of the lookup engine.
`timescale 1ns / 1ps

module sacache_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/sacache_front.sv */
// Request queue that splits each queued address into set, tag and block number.
`timescale 1ns / 1ps

module sacache_front #(
  parameter int SETS        = sacache_pkg::SETS_DEF,
  parameter int BLOCK_BYTES = sacache_pkg::BLOCK_BYTES_DEF,
  localparam int OB   = sacache_pkg::floor_log2(BLOCK_BYTES),
  localparam int IB   = sacache_pkg::floor_log2(SETS),
  localparam int SETW = sacache_pkg::idx_width(SETS),
  localparam int TAGW = sacache_pkg::ADDR_W - OB - IB,
  localparam int BLKW = sacache_pkg::ADDR_W - OB
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            hold,
  input  sacache_pkg::req_t req_in,
  output logic            full,
  input  logic            head_pop,
  output logic            head_valid,
  output logic            head_write,
  output logic [SETW-1:0] head_set,
  output logic [TAGW-1:0] head_tag,
  output logic [BLKW-1:0] head_blk
);

  localparam logic [31:0] SET_MASK = 32'((64'(1) << IB) - 64'(1));

  sacache_pkg::req_t head;
  logic              q_full;
  logic              q_empty;
  logic [31:0]       set_word;
  logic [31:0]       tag_word;

  sacache_fifo #(
    .WIDTH($bits(sacache_pkg::req_t)),
    .DEPTH(2)
  ) u_reqq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push && !hold),
    .wr_data(req_in),
    .rd_en  (head_pop),
    .rd_data(head),
    .full   (q_full),
    .empty  (q_empty)
  );

  assign full       = q_full || hold;
  assign head_valid = !q_empty;
  assign head_write = (head.req_type == sacache_pkg::REQ_WRITE);
  assign set_word   = (head.address >> OB) & SET_MASK;
  assign tag_word   = head.address >> (OB + IB);
  assign head_set   = set_word[SETW-1:0];
  assign head_tag   = tag_word[TAGW-1:0];
  assign head_blk   = head.address[sacache_pkg::ADDR_W-1:OB];

endmodule

/* design/sacache_engine.sv */
// Lookup engine: reads a set, resolves hit, eviction and victim cache, writes the set back.
`timescale 1ns / 1ps

module sacache_engine #(
  parameter int SETS        = sacache_pkg::SETS_DEF,
  parameter int WAYS        = sacache_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = sacache_pkg::BLOCK_BYTES_DEF,
  parameter int VC_ENTRIES  = sacache_pkg::VC_ENTRIES_DEF,
  localparam int OB   = sacache_pkg::floor_log2(BLOCK_BYTES),
  localparam int IB   = sacache_pkg::floor_log2(SETS),
  localparam int SETW = sacache_pkg::idx_width(SETS),
  localparam int TAGW = sacache_pkg::ADDR_W - OB - IB,
  localparam int BLKW = sacache_pkg::ADDR_W - OB
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              victim_enable,
  output logic              clearing,
  input  logic              head_valid,
  input  logic              head_write,
  input  logic [SETW-1:0]   head_set,
  input  logic [TAGW-1:0]   head_tag,
  input  logic [BLKW-1:0]   head_blk,
  output logic              head_pop,
  input  logic              res_space,
  output logic              res_push,
  output sacache_pkg::res_t res
);

  localparam int WAYW = sacache_pkg::idx_width(WAYS);
  localparam int VCW  = sacache_pkg::idx_width(VC_ENTRIES);

  typedef struct packed {
    logic [WAYS-1:0][TAGW-1:0] tag;
    logic [WAYS-1:0]           valid;
    logic [WAYS-1:0]           dirty;
    logic [WAYS-1:0][WAYW-1:0] age;
  } row_t;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t    state;
  logic [SETW-1:0] clr_idx;

  row_t      set_mem [SETS];
  row_t      rd_row;
  row_t      wr_row;
  logic      mem_we;
  logic [SETW-1:0] mem_addr;
  logic      rd_en;

  logic [VC_ENTRIES-1:0][BLKW-1:0] vc_block;
  logic [VC_ENTRIES-1:0]           vc_valid;
  logic [VC_ENTRIES-1:0]           vc_dirty;
  logic [VC_ENTRIES-1:0][VCW-1:0]  vc_age;

  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] way_max;
  logic            hit;
  logic [WAYW-1:0] hit_way;
  logic [WAYW-1:0] vic_way;
  logic [WAYW-1:0] touch_way;
  logic [WAYW-1:0] touch_age;
  logic [TAGW-1:0] ev_tag;
  logic            ev_valid;
  logic            ev_dirty;
  logic [BLKW-1:0] ev_blk;
  logic [31:0]     ev_word;
  logic            swap_req;
  logic            swap_hit;
  logic [VC_ENTRIES-1:0] vc_match;
  logic [VC_ENTRIES-1:0] vc_max;
  logic [VCW-1:0]  vc_hit_idx;
  logic [VCW-1:0]  vc_old_idx;
  logic [VCW-1:0]  vc_sel;
  logic [VCW-1:0]  vc_touch_age;
  logic            vc_wb;
  logic            plain_wb;

  assign clearing = (state == S_CLEAR);
  assign rd_en    = (state == S_IDLE) && head_valid && res_space;
  assign head_pop = (state == S_EXEC);
  assign res_push = (state == S_EXEC);
  assign mem_we   = (state == S_CLEAR) || (state == S_EXEC);
  assign mem_addr = (state == S_CLEAR) ? clr_idx : head_set;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      set_mem[mem_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= set_mem[head_set];
    end
  end

  // Way lookup and first way holding the largest age.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = rd_row.valid[i] && (rd_row.tag[i] == head_tag);
      way_max[i] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if (rd_row.age[j] > rd_row.age[i]) begin
          way_max[i] = 1'b0;
        end
      end
    end
    hit     = |hit_vec;
    hit_way = '0;
    vic_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAYW'(i);
      end
      if (way_max[i]) begin
        vic_way = WAYW'(i);
      end
    end
  end

  assign ev_tag   = rd_row.tag[vic_way];
  assign ev_valid = rd_row.valid[vic_way];
  assign ev_dirty = rd_row.dirty[vic_way];
  assign ev_word  = (32'(ev_tag) << IB) | 32'(head_set);
  assign ev_blk   = ev_word[BLKW-1:0];
  assign swap_req = !hit && victim_enable && ev_valid;

  // Victim cache search and its LRU entry.
  always_comb begin
    for (int e = 0; e < VC_ENTRIES; e++) begin
      vc_match[e] = vc_valid[e] && (vc_block[e] == head_blk);
      vc_max[e]   = 1'b1;
      for (int j = 0; j < VC_ENTRIES; j++) begin
        if (vc_age[j] > vc_age[e]) begin
          vc_max[e] = 1'b0;
        end
      end
    end
    vc_hit_idx = '0;
    vc_old_idx = '0;
    for (int e = VC_ENTRIES - 1; e >= 0; e--) begin
      if (vc_match[e]) begin
        vc_hit_idx = VCW'(e);
      end
      if (vc_max[e]) begin
        vc_old_idx = VCW'(e);
      end
    end
  end

  assign swap_hit     = swap_req && (|vc_match);
  assign vc_sel       = swap_hit ? vc_hit_idx : vc_old_idx;
  assign vc_touch_age = vc_age[vc_sel];
  assign vc_wb        = swap_req && !swap_hit && vc_valid[vc_old_idx] && vc_dirty[vc_old_idx];
  assign plain_wb     = !hit && !victim_enable && ev_dirty;
  assign touch_way    = hit ? hit_way : vic_way;
  assign touch_age    = rd_row.age[touch_way];

  // Row written back: cleared row during the sweep, updated row otherwise.
  always_comb begin
    wr_row = rd_row;
    if (state == S_CLEAR) begin
      wr_row = '0;
    end else begin
      for (int i = 0; i < WAYS; i++) begin
        if (WAYW'(i) == touch_way) begin
          wr_row.age[i] = '0;
        end else if (rd_row.age[i] <= touch_age) begin
          wr_row.age[i] = rd_row.age[i] + 1'b1;
        end
      end
      if (hit) begin
        wr_row.dirty[hit_way] = rd_row.dirty[hit_way] || head_write;
      end else begin
        wr_row.valid[vic_way] = 1'b1;
        wr_row.tag[vic_way]   = head_tag;
        wr_row.dirty[vic_way] = (swap_hit && !head_write) ? vc_dirty[vc_hit_idx] : head_write;
      end
    end
  end

  always_comb begin
    res                 = '0;
    res.hit             = hit;
    res.swap_request    = swap_req;
    res.swap_hit        = swap_hit;
    res.writeback_valid = vc_wb || plain_wb;
    if (vc_wb) begin
      res.writeback_block = {vc_block[vc_old_idx], {OB{1'b0}}};
    end else if (plain_wb) begin
      res.writeback_block = {ev_blk, {OB{1'b0}}};
    end
    res.fetch_valid = !hit && !swap_hit;
    if (!hit && !swap_hit) begin
      res.fetch_block = {head_blk, {OB{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      vc_block <= '0;
      vc_valid <= '0;
      vc_dirty <= '0;
      vc_age   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SETW'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rd_en) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          if (swap_req) begin
            vc_block[vc_sel] <= ev_blk;
            vc_dirty[vc_sel] <= ev_dirty;
            vc_valid[vc_sel] <= 1'b1;
            for (int e = 0; e < VC_ENTRIES; e++) begin
              if (VCW'(e) == vc_sel) begin
                vc_age[e] <= '0;
              end else if (vc_age[e] <= vc_touch_age) begin
                vc_age[e] <= vc_age[e] + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A swap hit never comes with a main-cache hit or a fetch.
  a_swap_hit_no_fetch: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.swap_hit) |-> (res.swap_request && !res.hit && !res.fetch_valid))
    else $error("swap hit with hit or fetch");

  // A result is only produced in the cycle after its set was read.
  a_push_after_read: assert property (@(posedge clk) disable iff (rst)
    res_push |-> $past(rd_en))
    else $error("result without a set read");

  // With the victim cache on, a writeback only follows a swap request that missed.
  a_wb_from_vc: assert property (@(posedge clk) disable iff (rst)
    (res_push && victim_enable && res.writeback_valid) |->
      (res.swap_request && !res.swap_hit))
    else $error("writeback without victim cache eviction");

  // No request leaves the queue during the clearing sweep.
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !head_pop)
    else $error("request taken during clear");

endmodule

/* design/set_assoc_cache_lru_victim.sv */
// Top level of the write-back set-associative cache tag store with LRU and victim cache.
`timescale 1ns / 1ps

// Usage
// Requests enter through a queue-like port: a transfer happens on a rising edge
// where push is high and full is low, carrying req_type (0 read, 1 write) and
// the byte address. Results leave through a second queue-like port: while empty
// is low the oldest result sits on hit, swap_request, swap_hit, writeback_*,
// and fetch_*; it is taken on an edge where pop is high.
// The victim cache is switched by cfg_write/cfg_data; write it only while idle.
// Each access passes two steps in the lookup engine: the set row is read from
// the tag memory, then the access is resolved and the row is written back. The
// engine takes no new access until the last one is written back, and reads a
// set only while the result queue has space; the resolve step pushes the result.
// After reset the engine sweeps the tag memory, clearing one set per cycle, until
// every set is clear; full stays high during the sweep. The victim cache and the
// enable register clear at once.
// When the receiver stops popping, results gather in a two-entry queue and the
// engine waits; requests gather in a two-entry queue in front until full rises.

module set_assoc_cache_lru_victim #(
  parameter int SETS        = sacache_pkg::SETS_DEF,
  parameter int WAYS        = sacache_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = sacache_pkg::BLOCK_BYTES_DEF,
  parameter int VC_ENTRIES  = sacache_pkg::VC_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [31:0] address,
  output logic        empty,
  input  logic        pop,
  output logic        hit,
  output logic        swap_request,
  output logic        swap_hit,
  output logic        writeback_valid,
  output logic [31:0] writeback_block,
  output logic        fetch_valid,
  output logic [31:0] fetch_block,
  input  logic        cfg_write,
  input  logic        cfg_data
);

  localparam int OB   = sacache_pkg::floor_log2(BLOCK_BYTES);
  localparam int IB   = sacache_pkg::floor_log2(SETS);
  localparam int SETW = sacache_pkg::idx_width(SETS);
  localparam int TAGW = sacache_pkg::ADDR_W - OB - IB;
  localparam int BLKW = sacache_pkg::ADDR_W - OB;

  logic              victim_enable;
  logic              clearing;
  sacache_pkg::req_t req_in;
  logic              head_valid;
  logic              head_write;
  logic [SETW-1:0]   head_set;
  logic [TAGW-1:0]   head_tag;
  logic [BLKW-1:0]   head_blk;
  logic              head_pop;
  logic              res_push;
  logic              res_full;
  sacache_pkg::res_t res_in;
  sacache_pkg::res_t res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      victim_enable <= 1'b0;
    end else if (cfg_write) begin
      victim_enable <= cfg_data;
    end
  end

  assign req_in.req_type = req_type;
  assign req_in.address  = address;

  // Front: request queue and address split.
  sacache_front #(
    .SETS       (SETS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .hold      (clearing),
    .req_in    (req_in),
    .full      (full),
    .head_pop  (head_pop),
    .head_valid(head_valid),
    .head_write(head_write),
    .head_set  (head_set),
    .head_tag  (head_tag),
    .head_blk  (head_blk)
  );

  // Back: tag memory, victim cache and replacement.
  sacache_engine #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .BLOCK_BYTES(BLOCK_BYTES),
    .VC_ENTRIES (VC_ENTRIES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .victim_enable(victim_enable),
    .clearing     (clearing),
    .head_valid   (head_valid),
    .head_write   (head_write),
    .head_set     (head_set),
    .head_tag     (head_tag),
    .head_blk     (head_blk),
    .head_pop     (head_pop),
    .res_space    (!res_full),
    .res_push     (res_push),
    .res          (res_in)
  );

  // Result queue toward the next level.
  sacache_fifo #(
    .WIDTH($bits(sacache_pkg::res_t)),
    .DEPTH(2)
  ) u_resq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .rd_en  (pop),
    .rd_data(res_out),
    .full   (res_full),
    .empty  (empty)
  );

  assign hit             = res_out.hit;
  assign swap_request    = res_out.swap_request;
  assign swap_hit        = res_out.swap_hit;
  assign writeback_valid = res_out.writeback_valid;
  assign writeback_block = res_out.writeback_block;
  assign fetch_valid     = res_out.fetch_valid;
  assign fetch_block     = res_out.fetch_block;

endmodule
